>>> rtl/bpq_pkg.sv
// Shared types and constants for the bounded priority queue.
package bpq_pkg;

  localparam int unsigned COUNT_WIDTH = 5;
  localparam logic [COUNT_WIDTH-1:0] MAX_ENTRIES_RESET = 5'd10;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REPORT = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_op_t;

endpackage

>>> rtl/bpq_if.sv
// Channel interfaces of the bounded priority queue: requests, results, configuration.
interface bpq_req_if #(
  parameter int unsigned VALUE_WIDTH    = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
);
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic signed [VALUE_WIDTH-1:0]    value;
  logic signed [PRIORITY_WIDTH-1:0] priority_req;

  modport source (output valid, req_type, value, priority_req, input ready);
  modport sink (input valid, req_type, value, priority_req, output ready);
endinterface

interface bpq_res_if #(
  parameter int unsigned VALUE_WIDTH    = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
);
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [VALUE_WIDTH-1:0]       result_value;
  logic signed [VALUE_WIDTH-1:0]       first_value;
  logic signed [VALUE_WIDTH-1:0]       last_value;
  logic signed [PRIORITY_WIDTH-1:0]    min_priority;
  logic [bpq_pkg::COUNT_WIDTH-1:0]     entry_count;

  modport source (output valid, status, result_value, first_value, last_value,
                  min_priority, entry_count, input ready);
  modport sink (input valid, status, result_value, first_value, last_value,
                min_priority, entry_count, output ready);
endinterface

interface bpq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpq_pkg::COUNT_WIDTH-1:0] max_entries;

  modport source (output valid, max_entries, input ready);
  modport sink (input valid, max_entries, output ready);
endinterface

>>> rtl/bpq_cell.sv
// Sorted queue cell: holds an entry; on insert shifts back or loads, on pop drops if last.
module bpq_cell #(
  parameter int unsigned VALUE_WIDTH    = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bpq_pkg::cell_op_t                op,
  input  logic [VALUE_WIDTH-1:0]           new_value,
  input  logic signed [PRIORITY_WIDTH-1:0] new_priority,
  input  logic                             prev_valid,
  input  logic                             prev_stays,
  input  logic [VALUE_WIDTH-1:0]           prev_value,
  input  logic signed [PRIORITY_WIDTH-1:0] prev_priority,
  input  logic                             next_valid,
  output logic                             valid,
  output logic                             stays,
  output logic                             is_last,
  output logic [VALUE_WIDTH-1:0]           value,
  output logic signed [PRIORITY_WIDTH-1:0] priority_held
);

  logic                             valid_next;
  logic [VALUE_WIDTH-1:0]           value_next;
  logic signed [PRIORITY_WIDTH-1:0] priority_next;

  assign stays   = valid && (priority_held >= new_priority);
  assign is_last = valid && !next_valid;

  always_comb begin
    valid_next    = valid;
    value_next    = value;
    priority_next = priority_held;
    if (op.push && !stays) begin
      if (prev_stays) begin
        valid_next    = 1'b1;
        value_next    = new_value;
        priority_next = new_priority;
      end else begin
        valid_next    = prev_valid;
        value_next    = prev_value;
        priority_next = prev_priority;
      end
    end else if (op.pop) begin
      valid_next = valid && next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value         <= value_next;
    priority_held <= priority_next;
  end

endmodule

>>> rtl/bounded_priority_queue_unit.sv
// Top level of the bounded priority queue built from a row of sorted cells.
// A request is accepted only while no result beat is pending. At the edge that accepts it,
// every cell of the row compares the pushed priority at once and shifts or loads its entry, or
// the last cell drops its entry on a pop. At the next edge the front and last entries, the
// minimum priority and the count are registered, and the result beat is offered from then on.
// The input opens again only after that beat has been taken, so the queue cannot take a new
// request before the result of the last one has been taken. Configuration writes are taken
// in any cycle and set the entry limit used by later pushes.
module bounded_priority_queue_unit #(
  parameter int unsigned DEPTH          = 16,
  parameter int unsigned VALUE_WIDTH    = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  bpq_req_if.sink    req,
  bpq_res_if.source  res,
  bpq_cfg_if.sink    cfg
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > bpq_pkg::COUNT_WIDTH) ? CW : bpq_pkg::COUNT_WIDTH;

  logic [bpq_pkg::COUNT_WIDTH-1:0] max_entries;
  logic [CW-1:0]                   held_count;
  logic                            busy;
  bpq_pkg::status_t                pend_status;
  logic [VALUE_WIDTH-1:0]          pend_result;
  logic                            accept;
  logic                            full;
  logic                            do_push;
  logic                            do_pop;
  bpq_pkg::cell_op_t               op;
  bpq_pkg::status_t                status_next;
  logic [VALUE_WIDTH-1:0]          result_next;
  logic [VALUE_WIDTH-1:0]          last_value;
  logic [PRIORITY_WIDTH-1:0]       last_priority;

  logic                             cell_valid    [DEPTH];
  logic                             cell_stays    [DEPTH];
  logic                             cell_last     [DEPTH];
  logic [VALUE_WIDTH-1:0]           cell_value    [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] cell_priority [DEPTH];

  assign accept    = req.valid && req.ready;
  assign req.ready = !busy && !res.valid;
  assign cfg.ready = 1'b1;

  assign full = (CMPW'(held_count) >= CMPW'(max_entries)) || cell_valid[DEPTH-1];

  always_comb begin
    do_push     = 1'b0;
    do_pop      = 1'b0;
    status_next = bpq_pkg::STATUS_OK;
    result_next = '0;
    unique case (req.req_type)
      bpq_pkg::REQ_PUSH: begin
        if (full) begin
          status_next = bpq_pkg::STATUS_FULL;
        end else begin
          do_push     = 1'b1;
          result_next = req.value;
        end
      end
      bpq_pkg::REQ_POP: begin
        if (!cell_valid[0]) begin
          status_next = bpq_pkg::STATUS_EMPTY;
        end else begin
          do_pop = 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            if (cell_last[i]) begin
              result_next = cell_value[i];
            end
          end
        end
      end
      default: begin
        status_next = bpq_pkg::STATUS_OK;
      end
    endcase
    op.push = accept && do_push;
    op.pop  = accept && do_pop;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                             p_valid;
    logic                             p_stays;
    logic [VALUE_WIDTH-1:0]           p_value;
    logic signed [PRIORITY_WIDTH-1:0] p_priority;
    logic                             n_valid;

    if (g == 0) begin : g_head
      assign p_valid    = 1'b0;
      assign p_stays    = 1'b1;
      assign p_value    = '0;
      assign p_priority = '0;
    end else begin : g_body
      assign p_valid    = cell_valid[g-1];
      assign p_stays    = cell_stays[g-1];
      assign p_value    = cell_value[g-1];
      assign p_priority = cell_priority[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign n_valid = 1'b0;
    end else begin : g_mid
      assign n_valid = cell_valid[g+1];
    end

    bpq_cell #(
      .VALUE_WIDTH    (VALUE_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .op            (op),
      .new_value     (req.value),
      .new_priority  (req.priority_req),
      .prev_valid    (p_valid),
      .prev_stays    (p_stays),
      .prev_value    (p_value),
      .prev_priority (p_priority),
      .next_valid    (n_valid),
      .valid         (cell_valid[g]),
      .stays         (cell_stays[g]),
      .is_last       (cell_last[g]),
      .value         (cell_value[g]),
      .priority_held (cell_priority[g])
    );
  end

  always_comb begin
    last_value    = '0;
    last_priority = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_last[i]) begin
        last_value    = last_value | cell_value[i];
        last_priority = last_priority | cell_priority[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= bpq_pkg::MAX_ENTRIES_RESET;
      held_count  <= '0;
      busy        <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        max_entries <= cfg.max_entries;
      end
      if (op.push) begin
        held_count <= held_count + CW'(1);
      end else if (op.pop) begin
        held_count <= held_count - CW'(1);
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy <= 1'b0;
      end
      if (busy) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
      pend_result <= result_next;
    end
    if (busy) begin
      res.status       <= pend_status;
      res.result_value <= pend_result;
      res.first_value  <= cell_valid[0] ? cell_value[0] : '0;
      res.last_value   <= last_value;
      res.min_priority <= last_priority;
      res.entry_count  <= bpq_pkg::COUNT_WIDTH'(held_count);
    end
  end

endmodule
